// File: rtl/core/wnm_pkg.sv
// Package for the wildcard name matcher: widths, register indexes, reset values,
// the configuration struct and the star character.
// No dependencies.
package wnm_pkg;

	// Character and pattern geometry
	localparam int CHAR_W            = 8;
	localparam int MAX_CHARS         = 16;
	localparam int PATTERN_CHARS_DEF = 16;
	localparam int LEN_W             = 5;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_IDX_W         = 2;

	localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 2'd3;

	// Reset values: pattern is a single star
	localparam logic [CFG_DATA_W-1:0] PATTERN_LOW_RST  = 64'd42;
	localparam logic [CFG_DATA_W-1:0] PATTERN_HIGH_RST = 64'd0;
	localparam logic [LEN_W-1:0]      PATTERN_LEN_RST  = 5'd1;

	// Configuration seen by the datapath; pattern[i] is pattern character i
	typedef struct packed {
		logic [MAX_CHARS-1:0][CHAR_W-1:0] pattern;
		logic [LEN_W-1:0]                 length;
		logic                             invert;
	} cfg_t;

endpackage

// File: rtl/core/wnm_name_if.sv
// Name character channel: one word is a character or an end-of-name mark.
// Depends on wnm_pkg.
interface wnm_name_if;
	logic                         valid;
	logic                         ready;
	logic [wnm_pkg::CHAR_W-1:0]   name_char;
	logic                         end_of_name;

	modport source (output valid, output name_char, output end_of_name, input ready);
	modport sink   (input valid, input name_char, input end_of_name, output ready);
endinterface

// File: rtl/core/wnm_result_if.sv
// Result channel: one word per finished name.
// No dependencies.
interface wnm_result_if;
	logic valid;
	logic ready;
	logic fulfilled;

	modport source (output valid, output fulfilled, input ready);
	modport sink   (input valid, input fulfilled, output ready);
endinterface

// File: rtl/core/wnm_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on wnm_pkg.
interface wnm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [wnm_pkg::CFG_IDX_W-1:0]     index;
	logic [wnm_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/wnm_cfg_regs.sv
// Configuration registers of the matcher, written over the cfg channel.
// Depends on wnm_pkg and wnm_cfg_if.
module wnm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	wnm_cfg_if.sink       cfg,
	output wnm_pkg::cfg_t settings,
	output logic          restart
);

	logic [wnm_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [wnm_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [wnm_pkg::LEN_W-1:0]      len_q;
	logic                           invert_q;
	logic                           wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	// Register file; unknown indexes are ignored but still restart the name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= wnm_pkg::PATTERN_LOW_RST;
			pat_high_q <= wnm_pkg::PATTERN_HIGH_RST;
			len_q      <= wnm_pkg::PATTERN_LEN_RST;
			invert_q   <= 1'b0;
		end else if (wr) begin
			case (cfg.index)
				wnm_pkg::REG_PATTERN_LOW:  pat_low_q  <= cfg.data;
				wnm_pkg::REG_PATTERN_HIGH: pat_high_q <= cfg.data;
				wnm_pkg::REG_PATTERN_LEN:  len_q      <= cfg.data[wnm_pkg::LEN_W-1:0];
				wnm_pkg::REG_INVERT:       invert_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign restart          = wr;
	assign settings.pattern = {pat_high_q, pat_low_q};
	assign settings.length  = len_q;
	assign settings.invert  = invert_q;

endmodule

// File: rtl/core/wnm_pos_update.sv
// Bit-parallel position update: star closure of the stored set (prefix tree),
// then one character step. Pure combinational logic.
// Depends on wnm_pkg.
module wnm_pos_update #(
	parameter int PATTERN_CHARS = wnm_pkg::PATTERN_CHARS_DEF
) (
	input  wnm_pkg::cfg_t               settings,
	input  logic [PATTERN_CHARS:0]      raw_set,
	input  logic [wnm_pkg::CHAR_W-1:0]  in_char,
	output logic [PATTERN_CHARS:0]      next_set,
	output logic                        match
);

	localparam int POS    = PATTERN_CHARS + 1;
	localparam int LEVELS = $clog2(POS);

	logic [wnm_pkg::LEN_W-1:0]  n_used;
	logic [PATTERN_CHARS-1:0]   in_use;
	logic [PATTERN_CHARS-1:0]   star;
	logic [PATTERN_CHARS-1:0]   hit;
	logic [LEVELS:0][POS-1:0]   gen;
	logic [LEVELS:0][POS-1:0]   prop;
	logic [POS-1:0]             cur;

	// Length saturates at the pattern capacity
	assign n_used = (settings.length > wnm_pkg::LEN_W'(PATTERN_CHARS)) ?
		wnm_pkg::LEN_W'(PATTERN_CHARS) : settings.length;

	// Per-position decode
	always_comb begin
		for (int i = 0; i < PATTERN_CHARS; i++) begin
			in_use[i] = wnm_pkg::LEN_W'(i) < n_used;
			star[i]   = in_use[i] && (settings.pattern[i] == wnm_pkg::STAR_CHAR);
			hit[i]    = in_use[i] && !star[i] && (settings.pattern[i] == in_char);
		end
	end

	// Star closure: an active star position activates the next one, as a
	// log-depth prefix tree over the positions
	always_comb begin
		gen[0]     = raw_set;
		prop[0][0] = 1'b0;
		for (int j = 1; j < POS; j++)
			prop[0][j] = star[j-1];
		for (int k = 0; k < LEVELS; k++) begin
			for (int j = 0; j < POS; j++) begin
				if (j >= (1 << k)) begin
					gen[k+1][j]  = gen[k][j] | (prop[k][j] & gen[k][j-(1 << k)]);
					prop[k+1][j] = prop[k][j] & prop[k][j-(1 << k)];
				end else begin
					gen[k+1][j]  = gen[k][j];
					prop[k+1][j] = prop[k][j];
				end
			end
		end
	end

	assign cur = gen[LEVELS];

	// End of name: match when the final position is reached
	always_comb begin
		match = 1'b0;
		for (int j = 0; j < POS; j++)
			if (wnm_pkg::LEN_W'(j) == n_used)
				match = cur[j];
	end

	// Character step: a star keeps its position, a literal hit moves on
	always_comb begin
		next_set = '0;
		for (int i = 0; i < PATTERN_CHARS; i++) begin
			if (cur[i] && star[i])
				next_set[i] = 1'b1;
			if (cur[i] && hit[i])
				next_set[i+1] = 1'b1;
		end
	end

endmodule

// File: rtl/core/wildcard_name_matcher.sv
// Top level of the wildcard name matcher: input register, position update,
// result register. Depends on wnm_pkg, the channel interfaces,
// wnm_cfg_regs and wnm_pos_update.
//
// Usage:
//   name   - sink of name words: one character each, or an end-of-name mark
//            (its character is ignored). A name is any number of characters
//            followed by one end mark.
//   result - source of one word (fulfilled) per end mark: pattern matched,
//            xor the invert register.
//   cfg    - register writes (pattern low/high, length, invert); always ready.
//            A write drops any name in progress. Write only while idle.
// An end mark moves from the stage 1 register to the result register.
// Throughput: one name word per cycle unless an end mark waits on the result;
// the bit-parallel update in wnm_pos_update steps a whole character at once.
// Stalls: a held result stops only the next end mark in the input register;
// up to that point characters keep flowing. The result word holds until taken.
// Reset: pattern "*", length 1, invert off, no name in progress, no result.
module wildcard_name_matcher #(
	parameter int PATTERN_CHARS = wnm_pkg::PATTERN_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wnm_name_if.sink      name,
	wnm_result_if.source  result,
	wnm_cfg_if.sink       cfg
);

	localparam logic [PATTERN_CHARS:0] START_SET = (PATTERN_CHARS + 1)'(1);

	wnm_pkg::cfg_t                settings;
	logic                         restart;
	logic                         valid_s1;
	logic [wnm_pkg::CHAR_W-1:0]   char_s1;
	logic                         end_s1;
	logic                         advance;
	logic [PATTERN_CHARS:0]       raw_q;
	logic [PATTERN_CHARS:0]       next_set;
	logic                         match;
	logic                         out_valid_q;
	logic                         fulfilled_q;

	wnm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.settings (settings),
		.restart  (restart)
	);

	wnm_pos_update #(
		.PATTERN_CHARS (PATTERN_CHARS)
	) u_upd (
		.settings (settings),
		.raw_set  (raw_q),
		.in_char  (char_s1),
		.next_set (next_set),
		.match    (match)
	);

	// Input word leaves stage 1 unless it is an end mark blocked by the result
	assign advance    = valid_s1 && (!end_s1 || !out_valid_q || result.ready);
	assign name.ready = !valid_s1 || advance;

	// Stage 1 input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (name.ready) begin
			valid_s1 <= name.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (name.valid && name.ready) begin
			char_s1 <= name.name_char;
			end_s1  <= name.end_of_name;
		end
	end

	// Position set, kept before star closure; restarts at an end mark or write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= START_SET;
		end else if (restart) begin
			raw_q <= START_SET;
		end else if (advance) begin
			raw_q <= end_s1 ? START_SET : next_set;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			fulfilled_q <= match ^ settings.invert;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.fulfilled = fulfilled_q;

endmodule

// File: dv/tb.sv
// Self-checking bench for wildcard_name_matcher: streams value names against random glob
// patterns and compares each fulfilled flag with a bit-parallel position-set predictor.
// Depends on wnm_pkg, the three channel interfaces and the matcher RTL.
module tb;
	import wnm_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int WORD_TARGET    = 1800;

	localparam logic [MAX_CHARS:0] START_POS = (MAX_CHARS + 1)'(1);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} name_word_t;

	logic clk;
	logic arst_n;

	wnm_name_if   name_ch ();
	wnm_result_if res_ch ();
	wnm_cfg_if    cfg_ch ();

	wildcard_name_matcher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.name   (name_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Words waiting for the driver, and fulfilled flags waiting for the result channel
	name_word_t name_words[$];
	logic       expected_fulfilled[$];

	// Predictor state: register copy and active pattern positions
	cfg_t               model_cfg;
	logic [MAX_CHARS:0] positions;

	// Configuration as the stimulus side last wrote it, used to shape names
	cfg_t              gen_cfg;
	logic [CHAR_W-1:0] letters [3];

	name_word_t next_word;
	int         gap_left;
	int         burst_left;
	logic [15:0] ready_mask;
	int         mask_age;
	int         idle_cycles;
	int         err_count;
	int         words_queued;
	int         names_seen;
	int         chars_seen;
	int         matches_seen;
	int         writes_done;
	int         settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int used_chars(input cfg_t c);
		return (c.length > MAX_CHARS) ? MAX_CHARS : int'(c.length);
	endfunction

	// A live star makes the position after it live as well
	function automatic logic [MAX_CHARS:0] close_star_runs(input cfg_t c,
			input logic [MAX_CHARS:0] live);
		int n;
		n = used_chars(c);
		for (int i = 0; i < n; i++)
			if (live[i] && c.pattern[i] == STAR_CHAR)
				live[i+1] = 1'b1;
		return live;
	endfunction

	// One name character: stars hold their position, literals step on a hit
	function automatic logic [MAX_CHARS:0] advance_positions(input cfg_t c,
			input logic [MAX_CHARS:0] live, input logic [CHAR_W-1:0] ch);
		logic [MAX_CHARS:0] nxt;
		int n;
		nxt = '0;
		n = used_chars(c);
		for (int i = 0; i < n; i++) begin
			if (live[i]) begin
				if (c.pattern[i] == STAR_CHAR)
					nxt[i] = 1'b1;
				else if (c.pattern[i] == ch)
					nxt[i+1] = 1'b1;
			end
		end
		return close_star_runs(c, nxt);
	endfunction

	function automatic cfg_t reset_cfg();
		cfg_t c;
		c.pattern        = '0;
		c.pattern[7:0]   = PATTERN_LOW_RST;
		c.pattern[15:8]  = PATTERN_HIGH_RST;
		c.length         = PATTERN_LEN_RST;
		c.invert         = 1'b0;
		return c;
	endfunction

	task automatic note_failure(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	// ---------------------------------------------------------------- monitor
	// Checks results first, then folds register writes and name words into the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_fulfilled.delete();
			model_cfg = reset_cfg();
			positions = close_star_runs(model_cfg, START_POS);
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_fulfilled.size() == 0)
					note_failure($sformatf("result fulfilled=%0b with no name pending",
						res_ch.fulfilled));
				else if (expected_fulfilled[0] !== res_ch.fulfilled) begin
					note_failure($sformatf("mismatch on name %0d: fulfilled exp %0b got %0b",
						names_seen - expected_fulfilled.size(), expected_fulfilled[0],
						res_ch.fulfilled));
					void'(expected_fulfilled.pop_front());
				end else
					void'(expected_fulfilled.pop_front());
			end

			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_PATTERN_LOW:  model_cfg.pattern[7:0]  = cfg_ch.data;
					REG_PATTERN_HIGH: model_cfg.pattern[15:8] = cfg_ch.data;
					REG_PATTERN_LEN:  model_cfg.length        = cfg_ch.data[LEN_W-1:0];
					REG_INVERT:       model_cfg.invert        = cfg_ch.data[0];
					default: ;
				endcase
				positions = close_star_runs(model_cfg, START_POS);
			end

			if (name_ch.valid && name_ch.ready) begin
				if (name_ch.end_of_name) begin
					expected_fulfilled.push_back(positions[used_chars(model_cfg)]
						^ model_cfg.invert);
					if (positions[used_chars(model_cfg)])
						matches_seen++;
					names_seen++;
					positions = close_star_runs(model_cfg, START_POS);
				end else begin
					chars_seen++;
					positions = advance_positions(model_cfg, positions, name_ch.name_char);
				end
			end
		end
	end

	// ---------------------------------------------------------------- driver
	// Bursts of random length separated by random gaps; a shown word holds until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_ch.valid       <= 1'b0;
			name_ch.name_char   <= '0;
			name_ch.end_of_name <= 1'b0;
			gap_left   = 0;
			burst_left = 1;
		end else if (!name_ch.valid || name_ch.ready) begin
			if (name_ch.valid) begin
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left > 0 || name_words.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				name_ch.valid <= 1'b0;
			end else begin
				next_word = name_words.pop_front();
				name_ch.valid       <= 1'b1;
				name_ch.name_char   <= next_word.ch;
				name_ch.end_of_name <= next_word.last;
			end
		end
	end

	// ---------------------------------------------------------------- result sink
	// Rotating ready mask, redrawn whenever the mask age wraps; a quarter of the masks never stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			ready_mask = '1;
			mask_age   = 0;
		end else begin
			if (mask_age == 63) begin
				mask_age = 0;
				if ($urandom_range(0, 3) == 0)
					ready_mask = '1;
				else
					ready_mask = 16'($urandom) | 16'h0101;
			end else
				mask_age++;
			ready_mask = {ready_mask[0], ready_mask[15:1]};
			res_ch.ready <= ready_mask[0];
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((name_ch.valid && name_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		writes_done++;
	endtask

	// Writes the registers flagged in sel; the rest keep their current values
	task automatic apply_cfg(input cfg_t c, input logic [3:0] sel);
		logic [CFG_DATA_W-1:0] d;
		if (sel[REG_PATTERN_LOW]) begin
			write_reg(REG_PATTERN_LOW, c.pattern[7:0]);
			gen_cfg.pattern[7:0] = c.pattern[7:0];
		end
		if (sel[REG_PATTERN_HIGH]) begin
			write_reg(REG_PATTERN_HIGH, c.pattern[15:8]);
			gen_cfg.pattern[15:8] = c.pattern[15:8];
		end
		if (sel[REG_PATTERN_LEN]) begin
			d = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
			d[LEN_W-1:0] = c.length;
			write_reg(REG_PATTERN_LEN, d);
			gen_cfg.length = c.length;
		end
		if (sel[REG_INVERT]) begin
			d = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
			d[0] = c.invert;
			write_reg(REG_INVERT, d);
			gen_cfg.invert = c.invert;
		end
		settings_used++;
		@(negedge clk);
	endtask

	// Everything sent, every result back, then time for the last end mark to settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (name_words.size() != 0 || name_ch.valid || expected_fulfilled.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_name(input logic [CHAR_W-1:0] text[$]);
		foreach (text[i])
			name_words.push_back('{ch: text[i], last: 1'b0});
		name_words.push_back('{ch: CHAR_W'($urandom_range(0, 255)), last: 1'b1});
		words_queued += text.size() + 1;
	endtask

	function automatic logic [CHAR_W-1:0] pick_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return letters[r % 3];
		else if (r == 7)
			return STAR_CHAR;
		else if (r == 8)
			return gen_cfg.pattern[$urandom_range(0, MAX_CHARS - 1)];
		else
			return CHAR_W'($urandom_range(0, 255));
	endfunction

	// Mostly names built to match the pattern, some of them damaged, the rest noise
	task automatic queue_random_name();
		logic [CHAR_W-1:0] text[$];
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 9);
		n = used_chars(gen_cfg);
		text.delete();
		if (kind <= 7) begin
			for (int i = 0; i < n; i++) begin
				if (gen_cfg.pattern[i] == STAR_CHAR)
					repeat ($urandom_range(0, 3)) text.push_back(pick_char());
				else
					text.push_back(gen_cfg.pattern[i]);
			end
			if (kind >= 6) begin
				pos = (text.size() == 0) ? 0 : $urandom_range(0, text.size() - 1);
				case ($urandom_range(0, 2))
					0: if (text.size() != 0) text[pos] = pick_char();
					1: if (text.size() != 0) text.delete(pos);
					default: text.insert(pos, pick_char());
				endcase
			end
		end else if (kind == 8) begin
			repeat ($urandom_range(0, 20)) text.push_back(pick_char());
		end else begin
			repeat ($urandom_range(0, 5)) text.push_back(CHAR_W'($urandom_range(0, 255)));
		end
		queue_name(text);
	endtask

	initial begin
		cfg_t              c;
		logic [CHAR_W-1:0] text[$];
		int                shape;
		int                r;
		bit                first_random;

		arst_n              = 1'b0;
		name_ch.valid       = 1'b0;
		name_ch.name_char   = '0;
		name_ch.end_of_name = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		res_ch.ready        = 1'b0;
		idle_cycles  = 0;
		err_count    = 0;
		words_queued = 0;
		names_seen   = 0;
		chars_seen   = 0;
		matches_seen = 0;
		writes_done  = 0;
		settings_used = 1;
		gen_cfg = reset_cfg();
		letters[0] = "a";
		letters[1] = "b";
		letters[2] = "c";

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Reset pattern is a lone star: empty name, extreme bytes, a literal star
		text.delete();
		queue_name(text);
		text = '{8'h00};
		queue_name(text);
		text = '{8'hFF, STAR_CHAR, "a"};
		queue_name(text);
		wait_idle();

		// Star then literals, where the match needs a retry further along the name
		c = reset_cfg();
		c.pattern[0] = STAR_CHAR;
		c.pattern[1] = "a";
		c.pattern[2] = "b";
		c.length     = 5'd3;
		apply_cfg(c, 4'b1111);
		text = '{"a", "a", "b"};
		queue_name(text);
		text = '{"a", "b"};
		queue_name(text);
		text = '{"a", "b", "b"};
		queue_name(text);
		wait_idle();

		// Empty pattern: only the empty name matches
		c.length = 5'd0;
		apply_cfg(c, 4'b0100);
		text.delete();
		queue_name(text);
		text = '{"x"};
		queue_name(text);
		wait_idle();

		// Oversized length saturates; zero byte is a plain character; inverted sense
		for (int i = 1; i < MAX_CHARS; i++)
			c.pattern[i] = STAR_CHAR;
		c.pattern[0] = 8'h00;
		c.length     = 5'd31;
		c.invert     = 1'b1;
		apply_cfg(c, 4'b1111);
		text = '{8'h00};
		queue_name(text);
		text = '{8'h01};
		queue_name(text);
		wait_idle();

		// Random settings, each followed by a batch of names
		first_random = 1'b1;
		while (words_queued < WORD_TARGET) begin
			for (int k = 0; k < 3; k++)
				letters[k] = CHAR_W'($urandom_range(0, 255));
			shape = $urandom_range(0, 9);
			for (int i = 0; i < MAX_CHARS; i++) begin
				r = $urandom_range(0, 9);
				case (shape)
					0: c.pattern[i] = 8'h00;
					1: c.pattern[i] = 8'hFF;
					2: c.pattern[i] = STAR_CHAR;
					default: c.pattern[i] = (r < 3) ? STAR_CHAR :
						(r < 9) ? letters[r % 3] : CHAR_W'($urandom_range(0, 255));
				endcase
			end
			case ($urandom_range(0, 9))
				0: c.length = LEN_W'($urandom_range(MAX_CHARS + 1, 31));
				1: c.length = 5'd0;
				2: c.length = LEN_W'(MAX_CHARS);
				3: c.length = 5'd1;
				default: c.length = LEN_W'($urandom_range(1, MAX_CHARS));
			endcase
			c.invert = 1'($urandom_range(0, 1));
			apply_cfg(c, first_random ? 4'b1111 : 4'($urandom_range(1, 15)));
			first_random = 1'b0;
			repeat ($urandom_range(4, 15)) queue_random_name();
			wait_idle();
		end

		wait_idle();
		if (expected_fulfilled.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_fulfilled.size()));
		if (err_count > 10)
			$display("%0d further mismatches not shown", err_count - 10);
		$display("Checked %0d names (%0d characters) under %0d pattern settings, %0d writes.",
			names_seen, chars_seen, settings_used, writes_done);
		$display("%0d names matched before inversion, %0d did not.",
			matches_seen, names_seen - matches_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
